// ===== hdl/csmp_pkg.sv =====
package csmp_pkg;

  localparam int MAX_CATEGORIES = 1024;
  localparam int WEIGHT_BITS    = 16;

  localparam int CAT_W  = $clog2(MAX_CATEGORIES);   // category index
  localparam int CNT_W  = CAT_W + 1;                // fill count, holds MAX_CATEGORIES
  localparam int CDF_W  = WEIGHT_BITS + CAT_W;      // prefix sum
  localparam int U_W    = 31;                       // uniform fraction, state >> 33
  localparam int SCL_W  = U_W + CDF_W;              // u * total, cdf * 2^31
  localparam int MUL_W  = 32;                       // shared multiplier operand

  localparam logic [63:0] LCG_MUL    = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD    = 64'd1442695040888963407;
  localparam logic [31:0] ROW_STRIDE = 32'd1000003;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // accumulator operations of the shared MAC
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD   = 2'd1;
  localparam logic [1:0] ACC_ADD    = 2'd2;
  localparam logic [1:0] ACC_ADD_HI = 2'd3;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] acc_op;
  } mac_ctrl_t;

endpackage

// ===== hdl/csmp_ifs.sv =====
interface csmp_in_if import csmp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_weight;
  logic [15:0]            row_index;
  logic [31:0]            sample_index;

  modport source (output valid, operation, weight, last_weight, row_index, sample_index,
                  input ready);
  modport sink   (input valid, operation, weight, last_weight, row_index, sample_index,
                  output ready);
endinterface

interface csmp_out_if import csmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAT_W-1:0] category;
  logic             zero_total;

  modport source (output valid, category, zero_total, input ready);
  modport sink   (input valid, category, zero_total, output ready);
endinterface

interface csmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/csmp_mac.sv =====
module csmp_mac import csmp_pkg::*; (
  input  logic             clk,
  input  mac_ctrl_t        ctrl,
  input  logic [MUL_W-1:0] mul_a,
  input  logic [MUL_W-1:0] mul_b,
  input  logic [63:0]      acc_init,
  output logic [63:0]      acc,
  output logic [63:0]      prod
);

  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:   acc_nxt = acc_init;
      ACC_ADD:    acc_nxt = acc_r + prod_r;
      ACC_ADD_HI: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
  end

  assign acc  = acc_r;
  assign prod = prod_r;

endmodule

// ===== hdl/categorical_sampler_core.sv =====
// Categorical sampler: inverse-CDF draw over a row of up to 1024 weights.
// in_ch carries requests. A load request (operation 0) appends one weight to
// the current row; last_weight closes the row and latches
// its sum as the row total. A sample request (operation 1) derives a 64-bit
// LCG state from base_seed, row_index and sample_index, scales the top 31
// bits by the row total and binary-searches the prefix-sum RAM.
// out_ch returns one result per sample: category and zero_total.
// cfg_ch writes base_seed; it is ready whenever out of reset and must be used
// only when idle.
// A sample runs the LCG and scale states (ST_ROW to ST_SCALE) on the one
// shared 32x32 multiplier, then one search step per halving of the range
// (ST_SRCH: RAM read, ST_CMP: compare), then a final ST_SRCH and ST_DONE,
// which raises out_ch.valid. The next request is taken back in ST_IDLE, so a
// sample holds in_ch until the sequencer returns there; a load does not hold
// it. in_ch.ready is high only while out of reset and idle.
// A finished result sits in the output register; if out_ch is stalled the
// next request is still accepted, and a further sample waits in its final
// state until the register frees.
// Reset clears the row state (count 0, total 0, row closed) and base_seed;
// the prefix-sum RAM is not cleared, as only written entries are ever used.
module categorical_sampler_core import csmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  csmp_in_if.sink    in_ch,
  csmp_out_if.source out_ch,
  csmp_cfg_if.sink   cfg_ch
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ROW   = 4'd1;   // row * stride, acc = seed base + C
  localparam logic [3:0] ST_SALO  = 4'd2;   // sidx * A low word
  localparam logic [3:0] ST_SAHI  = 4'd3;   // sidx * A high word
  localparam logic [3:0] ST_ADD1  = 4'd4;   // acc = first LCG state
  localparam logic [3:0] ST_M0    = 4'd5;   // second step, low x low
  localparam logic [3:0] ST_M1    = 4'd6;
  localparam logic [3:0] ST_M2    = 4'd7;
  localparam logic [3:0] ST_ADD2  = 4'd8;   // acc = second LCG state
  localparam logic [3:0] ST_SCALE = 4'd9;   // u * total
  localparam logic [3:0] ST_SRCH  = 4'd10;  // issue RAM read at mid
  localparam logic [3:0] ST_CMP   = 4'd11;  // compare, narrow range
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [63:0]      base_seed_r;
  logic [CNT_W-1:0] count_r;
  logic [CDF_W-1:0] running_r;
  logic [CDF_W-1:0] total_r;
  logic             row_closed_r;

  logic [15:0]      row_r;
  logic [31:0]      sidx_r;
  logic [63:0]      st1_r;
  logic             zero_r;
  logic [CAT_W-1:0] lo_r, lo_nxt;
  logic [CAT_W-1:0] hi_r, hi_nxt;
  logic [CAT_W-1:0] mid_r;
  logic [CDF_W-1:0] rd_r;

  logic             out_valid_r;
  logic [CAT_W-1:0] out_cat_r;
  logic             out_zero_r;

  logic [CDF_W-1:0] cdf_mem [MAX_CATEGORIES];

  // ---------------------------------------------------------------- handshakes
  logic in_fire, load_fire, samp_fire, out_free, done_fire;

  assign in_ch.ready  = rst_n && (state_r == ST_IDLE);
  assign cfg_ch.ready = rst_n;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign load_fire    = in_fire && (in_ch.operation == OP_LOAD);
  assign samp_fire    = in_fire && (in_ch.operation == OP_SAMPLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign done_fire    = (state_r == ST_DONE) && out_free;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.category   = out_cat_r;
  assign out_ch.zero_total = out_zero_r;

  // ---------------------------------------------------------------- load path
  // A closed row restarts at entry 0; weights past the last entry are dropped.
  logic [CNT_W-1:0] count_eff;
  logic [CDF_W-1:0] prev_sum;
  logic             store_en;
  logic [CDF_W-1:0] new_sum;

  assign count_eff = row_closed_r ? '0 : count_r;
  assign prev_sum  = row_closed_r ? '0 : running_r;
  assign store_en  = (count_eff < CNT_W'(MAX_CATEGORIES));
  assign new_sum   = prev_sum + CDF_W'(in_ch.weight);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seed_r  <= '0;
      count_r      <= '0;
      running_r    <= '0;
      total_r      <= '0;
      row_closed_r <= 1'b1;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        base_seed_r <= cfg_ch.data;
      end
      if (load_fire) begin
        count_r      <= store_en ? count_eff + CNT_W'(1) : count_eff;
        running_r    <= store_en ? new_sum : prev_sum;
        row_closed_r <= in_ch.last_weight;
        if (in_ch.last_weight) begin
          // count is never zero after a load, so the total is the running sum
          total_r <= store_en ? new_sum : prev_sum;
        end
      end
    end
  end

  // ---------------------------------------------------------------- CDF RAM
  logic [CAT_W:0]   mid_sum;
  logic [CAT_W-1:0] mid;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CAT_W:1];

  always_ff @(posedge clk) begin
    if (load_fire && store_en) begin
      cdf_mem[count_eff[CAT_W-1:0]] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SRCH) begin
      rd_r <= cdf_mem[mid];
    end
  end

  // ---------------------------------------------------------------- shared MAC
  mac_ctrl_t        mac_ctrl;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [63:0]      acc_init;
  logic [63:0]      acc;
  logic [63:0]      prod;
  logic [CDF_W-1:0] tot;

  // zero total falls back to 1.0
  assign tot = (total_r == '0) ? CDF_W'(1) << WEIGHT_BITS : total_r;

  always_comb begin
    mac_ctrl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    mul_a    = '0;
    mul_b    = '0;
    acc_init = LCG_ADD;
    case (state_r)
      ST_ROW: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        mul_a    = MUL_W'(row_r);
        mul_b    = ROW_STRIDE;
        acc_init = base_seed_r + LCG_ADD;
      end
      ST_SALO: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_ADD};
        mul_a    = sidx_r;
        mul_b    = LCG_MUL[31:0];
      end
      ST_SAHI: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_ADD};
        mul_a    = sidx_r;
        mul_b    = LCG_MUL[63:32];
      end
      ST_ADD1: begin
        mac_ctrl = '{mul_en: 1'b0, acc_op: ACC_ADD_HI};
      end
      ST_M0: begin
        // acc holds the first state here; it is parked in st1_r
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        mul_a    = acc[31:0];
        mul_b    = LCG_MUL[31:0];
      end
      ST_M1: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_ADD};
        mul_a    = st1_r[31:0];
        mul_b    = LCG_MUL[63:32];
      end
      ST_M2: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_ADD_HI};
        mul_a    = st1_r[63:32];
        mul_b    = LCG_MUL[31:0];
      end
      ST_ADD2: begin
        mac_ctrl = '{mul_en: 1'b0, acc_op: ACC_ADD_HI};
      end
      ST_SCALE: begin
        mac_ctrl = '{mul_en: 1'b1, acc_op: ACC_HOLD};
        mul_a    = MUL_W'(acc[63:33]);
        mul_b    = MUL_W'(tot);
      end
      default: begin
        mac_ctrl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
      end
    endcase
  end

  csmp_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .acc_init (acc_init),
    .acc      (acc),
    .prod     (prod)
  );

  // ---------------------------------------------------------------- search
  // cdf * 2^31 <= u * total: go right of mid
  logic [SCL_W-1:0] cdf_scaled;
  logic             go_right;

  assign cdf_scaled = {rd_r, {U_W{1'b0}}};
  assign go_right   = (cdf_scaled <= prod[SCL_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    case (state_r)
      ST_IDLE:  if (samp_fire) state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_SALO;
      ST_SALO:  state_nxt = ST_SAHI;
      ST_SAHI:  state_nxt = ST_ADD1;
      ST_ADD1:  state_nxt = ST_M0;
      ST_M0:    state_nxt = ST_M1;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_ADD2;
      ST_ADD2:  state_nxt = ST_SCALE;
      ST_SCALE: begin
        lo_nxt    = '0;
        // empty row leaves lo == hi == 0, so the answer is category 0
        hi_nxt    = (count_r == '0) ? '0 : CAT_W'(count_r - CNT_W'(1));
        state_nxt = ST_SRCH;
      end
      ST_SRCH:  state_nxt = (lo_r < hi_r) ? ST_CMP : ST_DONE;
      ST_CMP: begin
        if (go_right) begin
          lo_nxt = mid_r + CAT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRCH;
      end
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (samp_fire) begin
      row_r  <= in_ch.row_index;
      sidx_r <= in_ch.sample_index;
    end
    if (state_r == ST_M0) begin
      st1_r <= acc;
    end
    if (state_r == ST_SCALE) begin
      zero_r <= (total_r == '0);
    end
    if (state_r == ST_SRCH) begin
      mid_r <= mid;
    end
    if (done_fire) begin
      out_cat_r  <= lo_r;
      out_zero_r <= zero_r;
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CATEGORIES))
    else $error("row count beyond store depth");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (lo_r <= hi_r))
    else $error("search range inverted");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((mid_r >= lo_r) && (mid_r < hi_r)))
    else $error("probe outside search range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside final state");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    samp_fire |=> !in_ch.ready)
    else $error("sample request did not occupy the sequencer");

endmodule

// ===== test/tb_categorical_sampler_core.sv =====
`timescale 1ns / 100ps

module tb_categorical_sampler_core import csmp_pkg::*;;

  // one request on in_ch, as the sender sees it
  typedef struct packed {
    logic                   op;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last_mark;
    logic [15:0]            row;
    logic [31:0]            sidx;
  } sampler_req_t;

  // one result on out_ch
  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic             zero_total;
  } draw_result_t;

  // directed rows: a typed-in answer where it is obvious, else the predictor's
  typedef struct {
    sampler_req_t req;
    bit           typed;
    draw_result_t want;
  } dir_row_t;

  localparam int SETTLE_CYC  = 40;   // exceeds the worst sample latency, plus margin
  localparam int LONG_HOLD   = 600;  // receiver hold-off, long enough to back up in_ch

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  csmp_in_if  in_ch();
  csmp_out_if out_ch();
  csmp_cfg_if cfg_ch();

  categorical_sampler_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: seed register, prefix-sum store, row bookkeeping
  // ---------------------------------------------------------------------------
  logic [63:0]      seed_reg;
  logic [CDF_W-1:0] cdf_mem [MAX_CATEGORIES];
  int               n_cat;
  logic [CDF_W-1:0] row_total;
  bit               row_closed;

  draw_result_t     expected_draws[$];
  dir_row_t         dir_rows[$];
  int               n_fail;
  bit               steady_send;     // sender offers back to back when set
  int               hold_requests;   // bumped by the main flow to ask for a long hold-off
  int               holds_served;

  // A load appends one weight to the running prefix sum. Past MAX_CATEGORIES
  // the weight is dropped, but a last mark on it still closes the row.
  function automatic void append_weight(logic [WEIGHT_BITS-1:0] w, logic last_mark);
    if (row_closed) begin
      n_cat      = 0;
      row_closed = 1'b0;
    end
    if (n_cat < MAX_CATEGORIES) begin
      cdf_mem[n_cat] = ((n_cat > 0) ? cdf_mem[n_cat-1] : '0) + CDF_W'(w);
      n_cat++;
    end
    if (last_mark) begin
      row_total  = (n_cat > 0) ? cdf_mem[n_cat-1] : '0;
      row_closed = 1'b1;
    end
  endfunction

  // Inverse-CDF draw: two LCG steps, u = top 31 bits, then search for the
  // first entry with cdf*2^31 > u*total. Both sides stay below 2^57, so a
  // plain 64-bit compare is exact.
  function automatic draw_result_t predict_draw(logic [15:0] row, logic [31:0] sidx);
    logic [63:0]      st;
    logic [U_W-1:0]   u;
    logic [CDF_W-1:0] tot;
    logic [63:0]      lhs;
    logic [63:0]      rhs;
    int               lo;
    int               hi;
    int               mid;
    draw_result_t     r;
    st  = seed_reg + 64'(row) * 64'(ROW_STRIDE);
    st  = st + 64'(sidx) * LCG_MUL + LCG_ADD;
    st  = st * LCG_MUL + LCG_ADD;
    u   = st[63:33];
    tot = row_total;
    r.zero_total = (tot == '0);
    if (r.zero_total) tot = CDF_W'(1) << WEIGHT_BITS;   // fall back to 1.0
    lo = 0;
    if (n_cat > 0) begin
      hi = n_cat - 1;                                   // search bound
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        lhs = 64'(cdf_mem[mid]) << U_W;
        rhs = 64'(u) * 64'(tot);
        if (lhs <= rhs) lo = mid + 1;
        else hi = mid;
      end
    end
    r.category = CAT_W'(lo);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders. Fields that an operation ignores carry noise.
  // ---------------------------------------------------------------------------
  function automatic sampler_req_t load_req(logic [WEIGHT_BITS-1:0] w, logic last_mark);
    sampler_req_t r;
    r.op        = OP_LOAD;
    r.weight    = w;
    r.last_mark = last_mark;
    r.row       = 16'($urandom);
    r.sidx      = $urandom;
    return r;
  endfunction

  function automatic sampler_req_t draw_req();
    sampler_req_t r;
    r.op        = OP_SAMPLE;
    r.weight    = WEIGHT_BITS'($urandom);
    r.last_mark = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       r.row = '0;
      1:       r.row = '1;
      default: r.row = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       r.sidx = '0;
      1:       r.sidx = '1;
      default: r.sidx = $urandom;
    endcase
    return r;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_BITS'($urandom_range(0, 15));
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic void tab_load(logic [WEIGHT_BITS-1:0] w, logic last_mark);
    dir_row_t e;
    e.req   = load_req(w, last_mark);
    e.typed = 1'b0;
    e.want  = '0;
    dir_rows.push_back(e);
  endfunction

  // typed = 1: cat/zt are the answer; typed = 0: predictor decides
  function automatic void tab_draw(logic [15:0] row, logic [31:0] sidx, bit typed,
                                   int cat, bit zt);
    dir_row_t e;
    e.req       = draw_req();
    e.req.row   = row;
    e.req.sidx  = sidx;
    e.typed     = typed;
    e.want.category   = CAT_W'(cat);
    e.want.zero_total = zt;
    dir_rows.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gap, present at negedge, hold until accepted at posedge.
  // The predictor advances at the accepting edge.
  // ---------------------------------------------------------------------------
  function automatic int send_gap();
    int p;
    if (steady_send) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(sampler_req_t r, bit typed, draw_result_t want);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= r.op;
    in_ch.weight       <= r.weight;
    in_ch.last_weight  <= r.last_mark;
    in_ch.row_index    <= r.row;
    in_ch.sample_index <= r.sidx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (r.op == OP_LOAD) append_weight(r.weight, r.last_mark);
    else expected_draws.push_back(typed ? want : predict_draw(r.row, r.sidx));
  endtask

  // Stop offering, let every outstanding sample come back, then give the
  // sequencer its worst-case latency before anything touches the config.
  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    seed_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly whole rows followed by a few draws; some open rows (draws see the
  // partial prefix sums and the previous total) and some stray draws.
  task automatic random_traffic(int n_items);
    int           sent;
    int           kind;
    int           len;
    bit           zero_row;
    draw_result_t none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
                                               : $urandom_range(1, 12);
        zero_row = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          send_req(load_req(zero_row ? '0 : pick_weight(), i == len - 1), 1'b0, none);
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_req(draw_req(), 1'b0, none);
          sent++;
        end
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 4)) begin
          send_req(load_req(pick_weight(), 1'b0), 1'b0, none);
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_req(draw_req(), 1'b0, none);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_req(draw_req(), 1'b0, none);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result: category %0d zero_total %0b",
               out_ch.category, out_ch.zero_total);
        n_fail++;
      end else begin
        if (out_ch.category !== expected_draws[0].category) begin
          $error("category: expected %0d, got %0d",
                 expected_draws[0].category, out_ch.category);
          n_fail++;
        end
        if (out_ch.zero_total !== expected_draws[0].zero_total) begin
          $error("zero_total: expected %0b, got %0b",
                 expected_draws[0].zero_total, out_ch.zero_total);
          n_fail++;
        end
        void'(expected_draws.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready with short and long gaps, steady stretches, and a
  // long hold-off whenever the main flow asks for one. The hold-off is
  // counted here so the sender keeps pushing and the block backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int n;
    out_ch.ready = 1'b0;
    holds_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end
      p = $urandom_range(0, 9);
      if (p < 3) begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        n = (p < 8) ? $urandom_range(1, 3) : $urandom_range(15, 80);
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_LOAD;
    in_ch.weight       = '0;
    in_ch.last_weight  = 1'b0;
    in_ch.row_index    = '0;
    in_ch.sample_index = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    seed_reg      = '0;
    n_cat         = 0;
    row_total     = '0;
    row_closed    = 1'b1;
    n_fail        = 0;
    steady_send   = 1'b0;
    hold_requests = 0;

    // Directed table. Typed answers only where they cannot depend on the seed.
    tab_draw(16'h0000, 32'h0000_0000, 1, 0, 1);   // empty row after reset
    tab_load(16'h0000, 1'b0);                     // open row, no total yet
    tab_draw(16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1);   // one entry, total still zero
    tab_load(16'h0000, 1'b0);
    tab_load(16'hFFFF, 1'b1);                     // row 0,0,max
    tab_draw(16'h0000, 32'h0000_0000, 1, 2, 0);   // zero-width bins are skipped
    tab_draw(16'hFFFF, 32'hFFFF_FFFF, 1, 2, 0);
    tab_load(16'h0000, 1'b1);                     // single zero weight
    tab_draw(16'h1234, 32'h0000_0001, 1, 0, 1);
    tab_load(16'h0000, 1'b0);                     // all-zero row of four
    tab_load(16'h0000, 1'b0);
    tab_load(16'h0000, 1'b0);
    tab_load(16'h0000, 1'b1);
    tab_draw(16'h8000, 32'h8000_0000, 1, 3, 1);   // fallback total, search runs to the cap
    tab_load(16'hFFFF, 1'b1);                     // single full weight
    tab_draw(16'h0001, 32'h7FFF_FFFF, 1, 0, 0);
    tab_load(16'hFFFF, 1'b0);
    tab_load(16'h0001, 1'b0);
    tab_load(16'h8000, 1'b1);
    tab_draw(16'h5A5A, 32'hA5A5_A5A5, 0, 0, 0);
    tab_draw(16'hFFFF, 32'h0000_0000, 0, 0, 0);
    tab_load(16'h3039, 1'b0);                     // sample in an open row
    tab_draw(16'h0000, 32'hFFFF_FFFF, 0, 0, 0);
    tab_load(16'h0000, 1'b1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_seed(64'h0);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain_and_settle();

    // seed all ones, with a long receiver hold-off while requests keep coming
    write_seed('1);
    hold_requests++;
    random_traffic(150);
    drain_and_settle();

    // back-to-back requests
    write_seed({$urandom, $urandom});
    steady_send = 1'b1;
    random_traffic(200);
    drain_and_settle();

    write_seed({$urandom, $urandom});
    steady_send = 1'b0;
    hold_requests++;
    random_traffic(150);
    drain_and_settle();

    if (expected_draws.size() != 0) begin
      $error("%0d results never arrived", expected_draws.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
